>>> design/ageu_pkg.sv
`timescale 1ns / 1ps
package ageu_pkg;

   // Configuration register indexes.
   localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
   localparam logic [1:0] REG_UPDATE_SLOTS  = 2'd1;
   localparam logic [1:0] REG_EPSILON       = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int LR_W        = 32;
   localparam int EPS_W       = 16;

   localparam logic [LR_W-1:0]  LR_RESET  = 32'd655;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

endpackage

>>> design/ageu_sqrt_cell.sv
`timescale 1ns / 1ps
// One root bit per cell: two radicand bits move into the partial remainder.
module ageu_sqrt_cell #(
   parameter int RW = 24,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            valid_i,
   input  logic [2*RW-1:0] rad_i,
   input  logic [RW:0]     rem_i,
   input  logic [RW-1:0]   root_i,
   input  logic [SW-1:0]   side_i,
   output logic            valid_o,
   output logic [2*RW-1:0] rad_o,
   output logic [RW:0]     rem_o,
   output logic [RW-1:0]   root_o,
   output logic [SW-1:0]   side_o
);

   logic            valid_ff;
   logic [2*RW-1:0] rad_ff;
   logic [RW:0]     rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [SW-1:0]   side_ff;
   logic [RW+2:0]   rem_sh, trial, diff;
   logic            ge;

   always_comb begin
      rem_sh  = {rem_i, rad_i[2*RW-1 -: 2]};
      trial   = {1'b0, root_i, 2'b01};
      diff    = rem_sh - trial;
      ge      = (rem_sh >= trial);
      rem_in  = ge ? diff[RW:0] : rem_sh[RW:0];
      root_in = {root_i[RW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         rad_ff  <= rad_i << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign rad_o   = rad_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
   assign side_o  = side_ff;

endmodule

>>> design/ageu_div_cell.sv
`timescale 1ns / 1ps
// One quotient bit per cell, restoring division; the quotient shifts in
// behind the dividend bits that are consumed.
module ageu_div_cell #(
   parameter int RW = 24,
   parameter int QW = 33,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          valid_i,
   input  logic [QW-1:0] n_i,
   input  logic [RW-1:0] rem_i,
   input  logic [RW-1:0] root_i,
   input  logic [SW-1:0] side_i,
   output logic          valid_o,
   output logic [QW-1:0] n_o,
   output logic [RW-1:0] rem_o,
   output logic [RW-1:0] root_o,
   output logic [SW-1:0] side_o
);

   logic          valid_ff;
   logic [QW-1:0] n_ff;
   logic [RW-1:0] rem_ff, rem_in, root_ff;
   logic [SW-1:0] side_ff;
   logic [RW:0]   rem_sh, diff;
   logic          ge;

   always_comb begin
      rem_sh = {rem_i, n_i[QW-1]};
      diff   = rem_sh - {1'b0, root_i};
      ge     = (rem_sh >= {1'b0, root_i});
      rem_in = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         n_ff    <= {n_i[QW-2:0], ge};
         rem_ff  <= rem_in;
         root_ff <= root_i;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign n_o     = n_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
   assign side_o  = side_ff;

endmodule

>>> design/adagrad_element_update_core.sv
`timescale 1ns / 1ps
// Adagrad element update in signed fixed point. The core takes one transaction per clock
// cycle and returns one result transaction per input, in order. It is built around a row
// of RW square-root cells, one root bit each, where RW = (DATA_WIDTH + FRAC_BITS + 1) / 2,
// and a row of DATA_WIDTH + 1 divider cells, one quotient bit each. The whole pipeline
// advances together and holds only while a finished result waits on rsp_ready. Configuration
// registers are written through the csr_ port and should only change while no transaction
// is in flight.
module adagrad_element_update_core #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [DATA_WIDTH-1:0]          req_weight_in,
   input  logic        [DATA_WIDTH-1:0]          req_accum_in,
   input  logic signed [DATA_WIDTH-1:0]          req_grad,
   input  logic                                  req_last_element,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]          rsp_weight_out,
   output logic        [DATA_WIDTH-1:0]          rsp_accum_out,
   output logic                                  rsp_last_out,
   input  logic                                  csr_we,
   input  logic [ageu_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ageu_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int DW   = DATA_WIDTH;
   localparam int RW   = (DW + FRAC_BITS + 1) / 2;
   localparam int TW   = 2 * RW;
   localparam int NW   = ageu_pkg::LR_W + DW;
   localparam int QW   = DW + 1;
   localparam int TOPW = NW - QW;
   localparam int CW   = (TOPW > RW) ? TOPW : RW;
   localparam int SW1  = 3 + 2 * DW + NW;
   localparam int SW2  = 4 + 2 * DW;

   // Configuration registers.
   logic [ageu_pkg::LR_W-1:0]  lr_ff;
   logic                       upd_ff;
   logic [ageu_pkg::EPS_W-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= ageu_pkg::LR_RESET;
         upd_ff <= 1'b1;
         eps_ff <= ageu_pkg::EPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ageu_pkg::REG_LEARNING_RATE: lr_ff  <= csr_wdata[ageu_pkg::LR_W-1:0];
            ageu_pkg::REG_UPDATE_SLOTS:  upd_ff <= csr_wdata[0];
            ageu_pkg::REG_EPSILON:       eps_ff <= csr_wdata[ageu_pkg::EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Every stage moves together; the pipeline holds only while the output waits.
   logic en;
   logic out_valid_ff;
   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   // Stage A: capture the transaction and take the gradient magnitude.
   logic          a_valid_ff;
   logic [DW-1:0] a_w_ff, a_acc_ff, a_mag_ff, a_mag_in;
   logic          a_neg_ff, a_last_ff;

   assign a_mag_in = req_grad[DW-1] ? (~req_grad + 1'b1) : req_grad;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
      if (en) begin
         a_w_ff    <= req_weight_in;
         a_acc_ff  <= req_accum_in;
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= req_grad[DW-1];
         a_last_ff <= req_last_element;
      end
   end

   // Stage B: the squared gradient and the numerator of the step.
   logic            b_valid_ff;
   logic [DW-1:0]   b_w_ff, b_acc_ff;
   logic            b_neg_ff, b_last_ff;
   logic [2*DW-1:0] b_sq_ff, b_sq_in;
   logic [NW-1:0]   b_num_ff, b_num_in;

   always_comb begin
      b_sq_in  = (2 * DW)'(a_mag_ff) * (2 * DW)'(a_mag_ff);
      b_num_in = NW'(lr_ff) * NW'(a_mag_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         b_w_ff    <= a_w_ff;
         b_acc_ff  <= a_acc_ff;
         b_neg_ff  <= a_neg_ff;
         b_last_ff <= a_last_ff;
         b_sq_ff   <= b_sq_in >> FRAC_BITS;
         b_num_ff  <= b_num_in;
      end
   end

   // Stage C: saturating accumulator update (when slot updates are on), then the saturating epsilon add.
   logic            c_valid_ff;
   logic [DW-1:0]   c_w_ff, c_acc_ff, c_acc_in, c_s;
   logic            c_neg_ff, c_last_ff, c_nz_ff;
   logic [NW-1:0]   c_num_ff;
   logic [TW-1:0]   c_rad_ff;
   logic [2*DW:0]   c_sum;
   logic [DW:0]     c_es;

   always_comb begin
      c_sum = (2 * DW + 1)'(b_acc_ff) + (2 * DW + 1)'(b_sq_ff);
      if (!upd_ff) begin
         c_acc_in = b_acc_ff;
      end else if (c_sum[2*DW:DW] != '0) begin
         c_acc_in = '1;
      end else begin
         c_acc_in = c_sum[DW-1:0];
      end
      c_es = (DW + 1)'(c_acc_in) + (DW + 1)'(eps_ff);
      c_s  = c_es[DW] ? '1 : c_es[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
      if (en) begin
         c_w_ff    <= b_w_ff;
         c_acc_ff  <= c_acc_in;
         c_neg_ff  <= b_neg_ff;
         c_last_ff <= b_last_ff;
         c_nz_ff   <= (b_num_ff == '0);
         c_num_ff  <= b_num_ff;
         c_rad_ff  <= TW'(c_s) << FRAC_BITS;
      end
   end

   // Square-root cell row.
   logic            sq_v    [RW+1];
   logic [TW-1:0]   sq_rad  [RW+1];
   logic [RW:0]     sq_rem  [RW+1];
   logic [RW-1:0]   sq_root [RW+1];
   logic [SW1-1:0]  sq_side [RW+1];

   assign sq_v[0]    = c_valid_ff;
   assign sq_rad[0]  = c_rad_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = {c_last_ff, c_neg_ff, c_nz_ff, c_w_ff, c_acc_ff, c_num_ff};

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      ageu_sqrt_cell #(.RW(RW), .SW(SW1)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .valid_i(sq_v[i]), .rad_i(sq_rad[i]), .rem_i(sq_rem[i]),
         .root_i(sq_root[i]), .side_i(sq_side[i]),
         .valid_o(sq_v[i+1]), .rad_o(sq_rad[i+1]), .rem_o(sq_rem[i+1]),
         .root_o(sq_root[i+1]), .side_o(sq_side[i+1])
      );
   end

   // Stage D: quotients of 2^QW and above saturate; otherwise the high part of
   // the numerator seeds the divider remainder.
   logic            d_valid_ff;
   logic [QW-1:0]   d_n_ff;
   logic [RW-1:0]   d_rem_ff, d_root_ff;
   logic [SW2-1:0]  d_side_ff;
   logic [NW-1:0]   d_num;
   logic [TOPW-1:0] d_top;
   logic            d_ovf;

   always_comb begin
      d_num = sq_side[RW][NW-1:0];
      d_top = d_num[NW-1:QW];
      d_ovf = (CW'(d_top) >= CW'(sq_root[RW]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= sq_v[RW];
      end
      if (en) begin
         d_n_ff    <= d_num[QW-1:0];
         d_rem_ff  <= d_ovf ? '0 : d_top[RW-1:0];
         d_root_ff <= sq_root[RW];
         d_side_ff <= {sq_side[RW][SW1-1:NW], d_ovf};
      end
   end

   // Divider cell row.
   logic            dv_v    [QW+1];
   logic [QW-1:0]   dv_n    [QW+1];
   logic [RW-1:0]   dv_rem  [QW+1];
   logic [RW-1:0]   dv_root [QW+1];
   logic [SW2-1:0]  dv_side [QW+1];

   assign dv_v[0]    = d_valid_ff;
   assign dv_n[0]    = d_n_ff;
   assign dv_rem[0]  = d_rem_ff;
   assign dv_root[0] = d_root_ff;
   assign dv_side[0] = d_side_ff;

   for (genvar i = 0; i < QW; i++) begin : g_div
      ageu_div_cell #(.RW(RW), .QW(QW), .SW(SW2)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .valid_i(dv_v[i]), .n_i(dv_n[i]), .rem_i(dv_rem[i]),
         .root_i(dv_root[i]), .side_i(dv_side[i]),
         .valid_o(dv_v[i+1]), .n_o(dv_n[i+1]), .rem_o(dv_rem[i+1]),
         .root_o(dv_root[i+1]), .side_o(dv_side[i+1])
      );
   end

   // Output stage: clip the quotient, apply it to the weight and saturate.
   logic                 e_last, e_neg, e_nz, e_ovf;
   logic [DW-1:0]        e_w, e_acc, e_lim, e_q;
   logic signed [DW+1:0] e_sum;
   logic [DW-1:0]        e_w_in;
   logic [DW-1:0]        out_w_ff, out_acc_ff;
   logic                 out_last_ff;

   always_comb begin
      {e_last, e_neg, e_nz, e_w, e_acc, e_ovf} = dv_side[QW];
      e_lim = e_neg ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
      if (e_nz) begin
         e_q = '0;
      end else if (e_ovf || (dv_n[QW] > QW'(e_lim))) begin
         e_q = e_lim;
      end else begin
         e_q = dv_n[QW][DW-1:0];
      end
      if (e_neg) begin
         e_sum = $signed({{2{e_w[DW-1]}}, e_w}) + $signed({2'b00, e_q});
      end else begin
         e_sum = $signed({{2{e_w[DW-1]}}, e_w}) - $signed({2'b00, e_q});
      end
      if (e_sum > $signed({3'b000, {(DW - 1){1'b1}}})) begin
         e_w_in = {1'b0, {(DW - 1){1'b1}}};
      end else if (e_sum < $signed({3'b111, {(DW - 1){1'b0}}})) begin
         e_w_in = {1'b1, {(DW - 1){1'b0}}};
      end else begin
         e_w_in = e_sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_v[QW];
      end
      if (en) begin
         out_w_ff    <= e_w_in;
         out_acc_ff  <= e_acc;
         out_last_ff <= e_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_weight_out = out_w_ff;
   assign rsp_accum_out  = out_acc_ff;
   assign rsp_last_out   = out_last_ff;

   // The divider seed must already be below the root unless the quotient overflowed.
   a_seed_below_root: assert property (@(posedge clock) disable iff (reset)
      (d_valid_ff && !d_side_ff[0]) |-> (d_rem_ff < d_root_ff))
      else $error("divider seed not below the root");

   // The remainder leaving the divider row stays below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (dv_v[QW] && !dv_side[QW][0]) |-> (dv_rem[QW] < dv_root[QW]))
      else $error("divider remainder out of range");

   // The root remainder never exceeds twice the root.
   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      sq_v[RW] |-> ((RW + 2)'(sq_rem[RW]) <= ((RW + 2)'(sq_root[RW]) << 1)))
      else $error("square root remainder out of range");

endmodule

>>> dv/adagrad_element_update_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the Adagrad element update core. Every request transaction that
// the core accepts is run through a predictor in the bench, and the predicted update is
// queued. Every response transaction is compared field by field with the oldest entry.
module adagrad_element_update_core_tb;

   // The two-bit index has one code beyond the register list; writes to it are dropped.
   localparam logic [ageu_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
   localparam int                     PIPE_DEPTH   = 62;
   localparam int                     SETTLE       = PIPE_DEPTH + 10;
   localparam int                     STALL_LIMIT  = 3000;
   localparam logic [31:0]            SMAX         = 32'h7FFF_FFFF;
   localparam logic [31:0]            SMIN         = 32'h8000_0000;

   typedef struct packed {
      logic signed [31:0] weight;
      logic        [31:0] accum;
      logic               last;
   } elem_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_weight_in = '0;
   logic        [31:0] req_accum_in = '0;
   logic signed [31:0] req_grad = '0;
   logic req_last_element = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_weight_out;
   logic        [31:0] rsp_accum_out;
   logic rsp_last_out;
   logic csr_we = 1'b0;
   logic [ageu_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ageu_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // The bench's own copy of the configuration registers.
   logic [31:0] cfg_rate  = ageu_pkg::LR_RESET;
   logic        cfg_slots = 1'b1;
   logic [15:0] cfg_eps   = ageu_pkg::EPS_RESET;

   elem_update_type pending_updates[$];
   int  error_count   = 0;
   int  requests_seen = 0;
   int  updates_seen  = 0;
   int  config_writes = 0;
   int  send_gap_pct  = 0;
   int  recv_gap_pct  = 0;
   int  hold_cycles   = 0;
   int  quiet_cycles  = 0;

   adagrad_element_update_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_weight_in(req_weight_in), .req_accum_in(req_accum_in),
      .req_grad(req_grad), .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_weight_out(rsp_weight_out), .rsp_accum_out(rsp_accum_out),
      .rsp_last_out(rsp_last_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Predicts one element update from the current register copy. All intermediate values
   // are kept in 64 bits or more, which is wide enough for every product at the default widths.
   function automatic elem_update_type predict_update(logic signed [31:0] w, logic [31:0] a,
                                                      logic signed [31:0] g, logic last);
      logic               neg;
      logic        [63:0] mag, acc, s, root, cand, num, quo, lim;
      logic signed [65:0] nw;
      elem_update_type    r;
      neg = g[31];
      mag = neg ? (64'd0 - {32'hFFFF_FFFF, g}) : {32'd0, g};
      acc = {32'd0, a};
      if (cfg_slots) begin
         acc = acc + ((mag * mag) >> 16);
         if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      end
      s = acc + {48'd0, cfg_eps};
      if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      // Integer square root of s in Q16.16, built one bit at a time from the top.
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= (s << 16)) root = cand;
      end
      lim = neg ? {32'd0, SMIN} : {32'd0, SMAX};
      num = {32'd0, cfg_rate} * mag;
      if (num == 0) quo = '0;
      else if (root == 0) quo = lim;
      else begin
         quo = num / root;
         if (quo > lim) quo = lim;
      end
      nw = neg ? ($signed({{34{w[31]}}, w}) + $signed({2'b00, quo}))
               : ($signed({{34{w[31]}}, w}) - $signed({2'b00, quo}));
      if (nw > $signed({34'd0, SMAX})) nw = $signed({34'd0, SMAX});
      if (nw < $signed({{34{1'b1}}, SMIN})) nw = $signed({{34{1'b1}}, SMIN});
      r.weight = nw[31:0];
      r.accum  = acc[31:0];
      r.last   = last;
      return r;
   endfunction

   // Random words leaning towards the corners of the field; small values keep the weight
   // arithmetic away from saturation for much of the run.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return SMAX;
         2: return SMIN;
         3: return 32'hFFFF_FFFF;
         4, 5: return $urandom_range(32'h0002_0000);
         default: return $urandom;
      endcase
   endfunction

   // Request side: the prediction is made at the very edge at which the core takes the
   // transaction. Response side: each accepted result is checked against the oldest entry.
   always @(posedge clock) begin
      elem_update_type exp_upd;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_updates.push_back(predict_update(req_weight_in, req_accum_in,
                                                     req_grad, req_last_element));
            requests_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            updates_seen++;
            if (pending_updates.size() == 0) begin
               $display("%0t: unexpected response w=%h a=%h l=%b", $time,
                        rsp_weight_out, rsp_accum_out, rsp_last_out);
               error_count++;
            end else begin
               exp_upd = pending_updates.pop_front();
               if (rsp_weight_out !== exp_upd.weight) begin
                  $display("%0t: weight_out expected %h actual %h", $time,
                           exp_upd.weight, rsp_weight_out);
                  error_count++;
               end
               if (rsp_accum_out !== exp_upd.accum) begin
                  $display("%0t: accum_out expected %h actual %h", $time,
                           exp_upd.accum, rsp_accum_out);
                  error_count++;
               end
               if (rsp_last_out !== exp_upd.last) begin
                  $display("%0t: last_out expected %b actual %b", $time,
                           exp_upd.last, rsp_last_out);
                  error_count++;
               end
            end
         end
      end
   end

   // The receiver stalls at random, or holds off completely for a requested stretch.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // Watchdog: any cycle without a transaction on either channel counts towards the limit.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offers one request transaction and returns once the core has accepted it. Any idle
   // cycles come first, so valid is never lowered and raised at the same edge.
   task automatic send_element(input logic signed [31:0] w, input logic [31:0] a,
                               input logic signed [31:0] g, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_weight_in    <= w;
      req_accum_in     <= a;
      req_grad         <= g;
      req_last_element <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_element();
      send_element(pick_word(), pick_word(), pick_word(), 1'($urandom_range(1)));
   endtask

   // Lets the pipeline run dry before the registers are touched.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [ageu_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [ageu_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ageu_pkg::REG_LEARNING_RATE: cfg_rate  = value;
         ageu_pkg::REG_UPDATE_SLOTS:  cfg_slots = value[0];
         ageu_pkg::REG_EPSILON:       cfg_eps   = value[ageu_pkg::EPS_W-1:0];
         default: ;
      endcase
      config_writes++;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] rate, input logic slots,
                             input logic [15:0] eps);
      drain_pipeline();
      write_register(ageu_pkg::REG_LEARNING_RATE, rate);
      write_register(ageu_pkg::REG_UPDATE_SLOTS, {31'd0, slots});
      write_register(ageu_pkg::REG_EPSILON, {16'd0, eps});
   endtask

   // Reset values of the registers, with the extremes of every input field.
   task automatic test_reset_values();
      send_element(32'sd0, 32'd0, 32'sd0, 1'b0);
      send_element(SMAX, 32'hFFFF_FFFF, SMAX, 1'b1);
      send_element(SMIN, 32'hFFFF_FFFF, SMIN, 1'b0);
      send_element(SMIN, 32'd0, SMAX, 1'b1);
      send_element(SMAX, 32'd0, SMIN, 1'b0);
      send_element(32'sh0001_0000, 32'h0001_0000, 32'sh0001_0000, 1'b1);
      send_element(32'shFFFF_0000, 32'h0000_0001, 32'shFFFF_FFFF, 1'b0);
   endtask

   // Register extremes: zero and full-scale rate, slot updates off, zero and maximum
   // epsilon. Zero epsilon with a zero accumulator gives a zero root, and a write to the
   // unmapped index must leave every register untouched.
   task automatic test_register_extremes();
      set_config(32'hFFFF_FFFF, 1'b0, 16'd0);
      send_element(32'sd0, 32'd0, 32'sh0000_0100, 1'b0);
      send_element(32'sd5, 32'd0, 32'shFFFF_FF00, 1'b1);
      send_element(32'sd7, 32'd0, 32'sd0, 1'b0);
      send_element(SMAX, 32'hFFFF_FFFF, SMAX, 1'b1);
      send_element(SMIN, 32'd1, SMIN, 1'b0);
      set_config(32'd0, 1'b1, 16'hFFFF);
      send_element(SMAX, 32'd0, SMAX, 1'b1);
      send_element(32'sd3, 32'hFFFF_FFFF, SMIN, 1'b0);
      drain_pipeline();
      write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
      send_element(32'sd1, 32'h0000_0004, 32'sh0000_2000, 1'b1);
      set_config(ageu_pkg::LR_RESET, 1'b1, 16'd0);
      send_element(32'sd0, 32'd0, 32'sd0, 1'b0);
      send_element(32'sd9, 32'd0, 32'sd1, 1'b1);
      send_element(32'sd9, 32'd0, -32'sd1, 1'b0);
   endtask

   task automatic test_random_traffic(input int n, input int sgap, input int rgap);
      logic [31:0] rate;
      case ($urandom_range(3))
         0: rate = 32'hFFFF_FFFF;
         1: rate = $urandom_range(32'h0002_0000);
         default: rate = $urandom;
      endcase
      set_config(rate, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
      send_gap_pct = sgap;
      recv_gap_pct = rgap;
      repeat (n) send_random_element();
   endtask

   // The receiver holds off long enough for the pipeline to fill, while the sender keeps
   // offering transactions without a gap until the core stalls its input.
   task automatic test_backpressure();
      set_config($urandom, 1'b1, 16'd1);
      send_gap_pct = 0;
      recv_gap_pct = 0;
      hold_cycles  = 400;
      repeat (200) send_random_element();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_register_extremes();
      repeat (2) test_random_traffic(200, 33, 58);
      repeat (2) test_random_traffic(200, 58, 33);
      repeat (2) test_random_traffic(200, 0, 0);
      test_backpressure();
      drain_pipeline();
      $display("Covered %0d requests and %0d checked updates over %0d register writes,",
               requests_seen, updates_seen, config_writes);
      $display("including register extremes, zero roots and a long receiver hold-off.");
      if (error_count == 0 && pending_updates.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
